>>> rtl/brmf_pkg.sv
// Shared constants and types of the binary rank morphology filter.
package brmf_pkg;

	localparam int MASK_REACH = 2;
	localparam int MASK_SPAN = 2 * MASK_REACH + 1;
	localparam int MASK_W = MASK_SPAN * MASK_SPAN;
	localparam int THR_W = 5;
	localparam int SIZE_W = 11;
	localparam int GRAY_W = 8;
	localparam int POS_W = 10;
	localparam int CNT_W = $clog2(MASK_W + 1);
	localparam int CFG_DATA_W = MASK_W;
	localparam int OUT_DATA_W = ((1 + 2 * POS_W + 7) / 8) * 8;

	localparam logic [MASK_W-1:0] MASK_RESET = '1;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

	typedef enum logic [1:0] {
		REG_MASK = 2'd0,
		REG_THRESH = 2'd1,
		REG_WIDTH = 2'd2,
		REG_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ITEM_PIXEL = 1'b0,
		ITEM_FLUSH = 1'b1
	} item_kind_t;

endpackage

>>> rtl/binary_rank_morphology_filter.sv
// Top level of the binary rank morphology filter over a column-banked line memory.
// Latency path: a result is registered in the s1 read stage and then in the output register.
// Throughput: one beat per cycle unless the output stalls; the line memory is split into
// 2*min(RADIUS,2)+1 column banks, each read once per cycle, so one access fetches the whole window.
// Reset: registers take their reset values and all counters clear; the line memory is not
// cleared, since every tap that counts was written earlier in the same frame.
module binary_rank_morphology_filter
	import brmf_pkg::*;
#(
	parameter int RADIUS = 2,
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [GRAY_W-1:0] s_tdata, // [7:0] gray
	input logic s_tuser, // [0] mode
	output logic m_tvalid,
	input logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata, // [0] out_black, [10:1] out_x, [20:11] out_y
	output logic m_tlast, // frame_end
	input logic cfg_valid,
	output logic cfg_ready,
	input cfg_reg_t cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int K = (RADIUS < MASK_REACH) ? RADIUS : MASK_REACH;
	localparam int NB = 2 * K + 1;
	localparam int ROWS = 3 * RADIUS + 1;
	localparam int RING_W = $clog2(ROWS);
	localparam int BANK_W = $clog2(NB);
	localparam int BANK_DEPTH = (MAX_WIDTH + NB - 1) / NB;
	localparam int BA_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int DW = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);
	localparam int XE = CW + 2;
	localparam int YE = HW + 2;

	logic [MASK_W-1:0] mask_q;
	logic [THR_W-1:0] thr_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic [DW-1:0] lag;

	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic [BANK_W-1:0] in_bank_q;
	logic [BA_W-1:0] in_addr_q;
	logic [RING_W-1:0] in_ring_q;
	logic [DW-1:0] dist_q;
	logic [CW-1:0] cx_q;
	logic [YW-1:0] cy_q;
	logic [BANK_W-1:0] c_bank_q;
	logic [BA_W-1:0] c_addr_q;
	logic [RING_W-1:0] c_ring_q;

	logic out_move;
	logic adv;
	logic accept;
	logic size_write;
	logic input_done;
	logic wr_en;
	logic fg;
	logic emit;
	logic col_end;
	logic c_col_end;
	logic c_last;

	logic [BA_W-1:0] rd_addr [NB];
	logic [BANK_W-1:0] bsel [NB];
	logic [RING_W-1:0] rsel [NB];
	logic [NB-1:0] col_ok;
	logic [NB-1:0] row_ok;
	logic [NB-1:0] fwd_hit;
	logic [MASK_W-1:0] en;

	logic s1_valid;
	logic [MASK_W-1:0] en_s1;
	logic [BANK_W-1:0] bsel_s1 [NB];
	logic [RING_W-1:0] rsel_s1 [NB];
	logic [NB-1:0] fwd_hit_s1;
	logic [ROWS-1:0] fwd_bit_s1;
	logic fwd_val_s1;
	logic [CW-1:0] x_s1;
	logic [YW-1:0] y_s1;
	logic last_s1;

	logic [ROWS-1:0] word_fw [NB];
	logic [CNT_W-1:0] row_cnt [NB];
	logic [CNT_W-1:0] count;
	logic black;

	logic m_valid_q;
	logic m_black_q;
	logic [POS_W-1:0] m_x_q;
	logic [POS_W-1:0] m_y_q;
	logic m_last_q;

	always_comb begin
		if (width_q == '0) begin
			w = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(width_q);
		end
		if (height_q == '0) begin
			h = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(height_q);
		end
		lag = DW'(w) * DW'(RADIUS) + DW'(RADIUS);
	end

	always_comb begin
		out_move = !m_valid_q || m_tready;
		adv = !s1_valid || out_move;
		s_tready = adv;
		accept = s_tvalid && adv;
		cfg_ready = 1'b1;
		size_write = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
		input_done = row_q >= h;
		wr_en = accept && (s_tuser == ITEM_PIXEL) && !input_done;
		fg = s_tdata == '0;
		emit = (wr_en && ((dist_q + DW'(1)) > lag))
			|| (accept && (s_tuser == ITEM_FLUSH) && input_done);
		col_end = (WW'(col_q) + WW'(1)) == w;
		c_col_end = (WW'(cx_q) + WW'(1)) == w;
		c_last = c_col_end && ((HW'(cy_q) + HW'(1)) == h);
	end

	// Bank j holds window column j - c_bank_q, folded into -K..K.
	always_comb begin
		logic [BANK_W:0] bv;
		logic [RING_W:0] rv;
		logic [XE-1:0] xs;
		logic [YE-1:0] ys;
		for (int j = 0; j < NB; j++) begin
			if (BANK_W'(j) >= c_bank_q) begin
				if ((BANK_W'(j) - c_bank_q) > BANK_W'(K)) begin
					rd_addr[j] = c_addr_q - BA_W'(1);
				end else begin
					rd_addr[j] = c_addr_q;
				end
			end else begin
				if ((c_bank_q - BANK_W'(j)) > BANK_W'(K)) begin
					rd_addr[j] = c_addr_q + BA_W'(1);
				end else begin
					rd_addr[j] = c_addr_q;
				end
			end
			fwd_hit[j] = wr_en && (in_bank_q == BANK_W'(j)) && (in_addr_q == rd_addr[j]);

			bv = (BANK_W + 1)'(c_bank_q) + (BANK_W + 1)'(j);
			if (bv < (BANK_W + 1)'(K)) begin
				bsel[j] = BANK_W'(bv + (BANK_W + 1)'(NB - K));
			end else if ((bv - (BANK_W + 1)'(K)) >= (BANK_W + 1)'(NB)) begin
				bsel[j] = BANK_W'(bv - (BANK_W + 1)'(K + NB));
			end else begin
				bsel[j] = BANK_W'(bv - (BANK_W + 1)'(K));
			end

			rv = (RING_W + 1)'(c_ring_q) + (RING_W + 1)'(j);
			if (rv < (RING_W + 1)'(K)) begin
				rsel[j] = RING_W'(rv + (RING_W + 1)'(ROWS - K));
			end else if ((rv - (RING_W + 1)'(K)) >= (RING_W + 1)'(ROWS)) begin
				rsel[j] = RING_W'(rv - (RING_W + 1)'(K + ROWS));
			end else begin
				rsel[j] = RING_W'(rv - (RING_W + 1)'(K));
			end

			xs = XE'(cx_q) + XE'(j);
			col_ok[j] = (xs >= XE'(K)) && (xs < (XE'(w) + XE'(K)));
			ys = YE'(cy_q) + YE'(j);
			row_ok[j] = (ys >= YE'(K)) && (ys < (YE'(h) + YE'(K)));
		end
		for (int dy = 0; dy < MASK_SPAN; dy++) begin
			for (int dx = 0; dx < MASK_SPAN; dx++) begin
				if (dy - MASK_REACH + K >= 0 && dy - MASK_REACH + K < NB
						&& dx - MASK_REACH + K >= 0 && dx - MASK_REACH + K < NB) begin
					en[dy * MASK_SPAN + dx] = mask_q[dy * MASK_SPAN + dx]
						& row_ok[dy - MASK_REACH + K] & col_ok[dx - MASK_REACH + K];
				end else begin
					en[dy * MASK_SPAN + dx] = 1'b0;
				end
			end
		end
	end

	for (genvar gb = 0; gb < NB; gb++) begin : g_bank
		logic [ROWS-1:0] mem_q [BANK_DEPTH];
		logic [ROWS-1:0] rd_s1;

		always_ff @(posedge clk) begin
			if (wr_en && in_bank_q == BANK_W'(gb)) begin
				mem_q[in_addr_q][in_ring_q] <= fg;
			end
			if (adv) begin
				rd_s1 <= mem_q[rd_addr[gb]];
			end
		end

		assign word_fw[gb] = fwd_hit_s1[gb]
			? ((rd_s1 & ~fwd_bit_s1) | (fwd_val_s1 ? fwd_bit_s1 : '0)) : rd_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			en_s1 <= en;
			bsel_s1 <= bsel;
			rsel_s1 <= rsel;
			fwd_hit_s1 <= fwd_hit;
			fwd_bit_s1 <= ROWS'(1) << in_ring_q;
			fwd_val_s1 <= fg;
			x_s1 <= cx_q;
			y_s1 <= cy_q;
			last_s1 <= c_last;
		end
	end

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			row_cnt[i] = '0;
			for (int k = 0; k < NB; k++) begin
				row_cnt[i] = row_cnt[i] + CNT_W'(word_fw[bsel_s1[k]][rsel_s1[i]]
					& en_s1[(i - K + MASK_REACH) * MASK_SPAN + k - K + MASK_REACH]);
			end
		end
		count = '0;
		for (int i = 0; i < NB; i++) begin
			count = count + row_cnt[i];
		end
		black = count >= CNT_W'(thr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
			thr_q <= THR_RESET;
			width_q <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MASK: mask_q <= cfg_data;
				REG_THRESH: thr_q <= cfg_data[THR_W-1:0];
				REG_WIDTH: width_q <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				default: mask_q <= mask_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			in_bank_q <= '0;
			in_addr_q <= '0;
			in_ring_q <= '0;
			dist_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			c_bank_q <= '0;
			c_addr_q <= '0;
			c_ring_q <= '0;
		end else if (size_write || (emit && c_last)) begin
			col_q <= '0;
			row_q <= '0;
			in_bank_q <= '0;
			in_addr_q <= '0;
			in_ring_q <= '0;
			dist_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			c_bank_q <= '0;
			c_addr_q <= '0;
			c_ring_q <= '0;
		end else begin
			if (wr_en) begin
				if (col_end) begin
					col_q <= '0;
					in_bank_q <= '0;
					in_addr_q <= '0;
					row_q <= row_q + HW'(1);
					in_ring_q <= (in_ring_q == RING_W'(ROWS - 1)) ? '0 : in_ring_q + RING_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
					if (in_bank_q == BANK_W'(NB - 1)) begin
						in_bank_q <= '0;
						in_addr_q <= in_addr_q + BA_W'(1);
					end else begin
						in_bank_q <= in_bank_q + BANK_W'(1);
					end
				end
			end
			if (wr_en && !emit) begin
				dist_q <= dist_q + DW'(1);
			end else if (emit && !wr_en) begin
				dist_q <= dist_q - DW'(1);
			end
			if (emit) begin
				if (c_col_end) begin
					cx_q <= '0;
					c_bank_q <= '0;
					c_addr_q <= '0;
					cy_q <= cy_q + YW'(1);
					c_ring_q <= (c_ring_q == RING_W'(ROWS - 1)) ? '0 : c_ring_q + RING_W'(1);
				end else begin
					cx_q <= cx_q + CW'(1);
					if (c_bank_q == BANK_W'(NB - 1)) begin
						c_bank_q <= '0;
						c_addr_q <= c_addr_q + BA_W'(1);
					end else begin
						c_bank_q <= c_bank_q + BANK_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				s1_valid <= emit;
			end
			if (out_move) begin
				m_valid_q <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_move && s1_valid) begin
			m_black_q <= black;
			m_x_q <= POS_W'(x_s1);
			m_y_q <= POS_W'(y_s1);
			m_last_q <= last_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {{(OUT_DATA_W - 2 * POS_W - 1){1'b0}}, m_y_q, m_x_q, m_black_q};
	assign m_tlast = m_last_q;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench of the binary rank morphology filter with a scoreboard.
module tb_top
	import brmf_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAD = 2;
	localparam int MAX_W = 1024;
	localparam int LINES = 3 * RAD + 1;

	typedef struct packed {
		logic black;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic last;
	} morph_px_t;

	class morph_board;
		logic [MASK_W-1:0] mask;
		logic [THR_W-1:0] thresh;
		logic [SIZE_W-1:0] width_reg;
		logic [SIZE_W-1:0] height_reg;
		bit fg_ring [LINES][MAX_W];
		int unsigned in_x;
		int unsigned in_y;
		int unsigned out_idx;
		morph_px_t expected_px [$];
		int unsigned errors;
		int unsigned beats;
		int unsigned results;

		function new();
			mask = MASK_RESET;
			thresh = THR_RESET;
			width_reg = SIZE_RESET;
			height_reg = SIZE_RESET;
			errors = 0;
			beats = 0;
			results = 0;
			restart();
		endfunction

		static function int unsigned span(logic [SIZE_W-1:0] v);
			if (v == 0) return 1;
			if (v > MAX_W) return MAX_W;
			return 32'(v);
		endfunction

		function void restart();
			in_x = 0;
			in_y = 0;
			out_idx = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_MASK: mask = val;
				REG_THRESH: thresh = val[THR_W-1:0];
				REG_WIDTH: begin
					width_reg = val[SIZE_W-1:0];
					restart();
				end
				REG_HEIGHT: begin
					height_reg = val[SIZE_W-1:0];
					restart();
				end
			endcase
		endfunction

		function void rank_result(int unsigned w, int unsigned h);
			int unsigned cx;
			int unsigned cy;
			int unsigned hits;
			int nx;
			int ny;
			int tap;
			int dx;
			int dy;
			morph_px_t px;
			cx = out_idx % w;
			cy = out_idx / w;
			hits = 0;
			for (dy = -MASK_REACH; dy <= MASK_REACH; dy++) begin
				for (dx = -MASK_REACH; dx <= MASK_REACH; dx++) begin
					tap = (dy + MASK_REACH) * MASK_SPAN + dx + MASK_REACH;
					nx = int'(cx) + dx;
					ny = int'(cy) + dy;
					if (mask[tap] && nx >= 0 && ny >= 0 && nx < int'(w) && ny < int'(h)) begin
						if (fg_ring[ny % LINES][nx]) hits++;
					end
				end
			end
			out_idx++;
			px.black = (hits >= thresh);
			px.x = cx[POS_W-1:0];
			px.y = cy[POS_W-1:0];
			px.last = (out_idx >= w * h);
			expected_px.push_back(px);
			if (px.last) restart();
		endfunction

		function void accept_beat(item_kind_t kind, logic [GRAY_W-1:0] gray);
			int unsigned w;
			int unsigned h;
			w = span(width_reg);
			h = span(height_reg);
			beats++;
			if (kind == ITEM_PIXEL) begin
				if (in_y >= h) return;
				fg_ring[in_y % LINES][in_x] = (gray == 0);
				in_x++;
				if (in_x >= w) begin
					in_x = 0;
					in_y++;
				end
				if (out_idx + RAD * w + RAD < in_y * w + in_x) rank_result(w, h);
			end else if (in_y >= h && out_idx < w * h) begin
				rank_result(w, h);
			end
		endfunction

		function void check_pixel(morph_px_t got);
			morph_px_t want;
			results++;
			if (expected_px.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result black=%0b x=%0d y=%0d last=%0b",
						$time, got.black, got.x, got.y, got.last);
				return;
			end
			want = expected_px.pop_front();
			if (got.black !== want.black || got.x !== want.x || got.y !== want.y ||
					got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("%0t: black/x/y/last expected %0b/%0d/%0d/%0b, got %0b/%0d/%0d/%0b",
						$time, want.black, want.x, want.y, want.last,
						got.black, got.x, got.y, got.last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [GRAY_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	cfg_reg_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	morph_board board = new();
	bit calm = 1'b0;
	int hold_req = 0;
	int hold_done = 0;
	int unsigned sent = 0;
	int unsigned frames = 0;
	int unsigned writes = 0;

	binary_rank_morphology_filter u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) board.accept_beat(item_kind_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready)
				board.check_pixel({m_tdata[0], m_tdata[10:1], m_tdata[20:11], m_tlast});
		end
	end

	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				m_tready <= 1'b0;
				repeat (299) @(posedge clk);
				hold_done++;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 5)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic set_reg(cfg_reg_t idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		writes++;
	endtask

	task automatic push_item(item_kind_t kind, int unsigned gray);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= GRAY_W'(gray);
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic settle();
		while (board.expected_px.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [MASK_W-1:0] pick_mask();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			2: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
			// Centered 3x3 box.
			3: return MASK_W'(25'h00739C0);
			// Plus-shaped cross through the center.
			4: return MASK_W'(25'h0427C84);
			default: return MASK_W'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_thresh(logic [MASK_W-1:0] m);
		case ($urandom_range(0, 4))
			0: return 1;
			1: return $countones(m);
			2: return $countones(m) / 2;
			3: return $urandom_range(0, 31);
			default: return $urandom_range(0, $countones(m));
		endcase
	endfunction

	task automatic run_frame(int unsigned w_reg, int unsigned h_reg, bit noisy, int split_at,
			int stop_at);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned drains;
		int unsigned dens;
		logic [MASK_W-1:0] m;
		set_reg(REG_WIDTH, w_reg);
		set_reg(REG_HEIGHT, h_reg);
		w = morph_board::span(SIZE_W'(w_reg));
		h = morph_board::span(SIZE_W'(h_reg));
		total = w * h;
		drains = (total < RAD * w + RAD) ? total : RAD * w + RAD;
		dens = $urandom_range(5, 95);
		for (int i = 0; i < int'(total); i++) begin
			if (i == stop_at) begin
				s_tvalid <= 1'b0;
				return;
			end
			if (i == split_at) begin
				s_tvalid <= 1'b0;
				settle();
				m = pick_mask();
				set_reg(REG_MASK, m);
				set_reg(REG_THRESH, pick_thresh(m));
			end
			if (noisy && $urandom_range(0, 9) == 0) push_item(ITEM_FLUSH, $urandom_range(0, 255));
			push_item(ITEM_PIXEL, ($urandom_range(0, 99) < dens) ? 0 : $urandom_range(0, 255));
		end
		for (int j = 0; j < int'(drains); j++) begin
			if (noisy && $urandom_range(0, 9) == 0) push_item(ITEM_PIXEL, $urandom_range(0, 255));
			push_item(ITEM_FLUSH, $urandom_range(0, 255));
		end
		s_tvalid <= 1'b0;
		frames++;
	endtask

	initial begin
		int unsigned base;
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int split;
		int stop;
		logic [MASK_W-1:0] m;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= ITEM_PIXEL;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MASK;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero sizes act as a 1x1 frame; an early flush, a surplus pixel and a late flush give nothing.
		set_reg(REG_WIDTH, 0);
		set_reg(REG_HEIGHT, 0);
		push_item(ITEM_FLUSH, 255);
		push_item(ITEM_PIXEL, 0);
		push_item(ITEM_PIXEL, 255);
		push_item(ITEM_FLUSH, 0);
		push_item(ITEM_FLUSH, 8'h80);
		s_tvalid <= 1'b0;
		frames++;
		settle();

		// A partial frame is abandoned by the size write that follows it.
		set_reg(REG_WIDTH, 3);
		set_reg(REG_HEIGHT, 2);
		push_item(ITEM_PIXEL, 0);
		push_item(ITEM_PIXEL, 0);
		s_tvalid <= 1'b0;
		settle();
		set_reg(REG_THRESH, 0);
		run_frame(2, 2, 0, -1, -1);
		settle();
		set_reg(REG_MASK, 0);
		set_reg(REG_THRESH, 31);
		run_frame(1, 3, 0, -1, -1);
		settle();

		// Oversized registers act as the maximum; these frames are cut short.
		m = pick_mask();
		set_reg(REG_MASK, m);
		set_reg(REG_THRESH, pick_thresh(m));
		run_frame(2047, 1, 1, -1, 60);
		settle();
		m = pick_mask();
		set_reg(REG_MASK, m);
		set_reg(REG_THRESH, pick_thresh(m));
		run_frame(1, 2047, 0, -1, 120);
		settle();

		base = sent;
		set_reg(REG_MASK, '1);
		set_reg(REG_THRESH, 13);
		hold_req++;
		run_frame(8, 8, 0, -1, -1);
		while (sent - base < 400) begin
			if (sent - base >= 320) calm = 1'b1;
			settle();
			m = pick_mask();
			set_reg(REG_MASK, m);
			set_reg(REG_THRESH, pick_thresh(m));
			w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			total = morph_board::span(SIZE_W'(w)) * morph_board::span(SIZE_W'(h));
			split = -1;
			stop = -1;
			if ($urandom_range(0, 3) == 0) split = $urandom_range(0, total - 1);
			if ($urandom_range(0, 7) == 0) stop = $urandom_range(1, total);
			run_frame(w, h, $urandom_range(0, 2) == 0, split, stop);
		end
		settle();
		board.errors += board.expected_px.size();

		$display("Run covered %0d input beats and %0d checked results over %0d frames.",
			board.beats, board.results, frames);
		$display("It made %0d register writes, with sizes from 0 to 2047 and thresholds 0 to 31.",
			writes);
		if (board.errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
